### hw/rtl/dcm_pkg.sv
// Shared constants, types and factor tables of the depth median and decimation block.
package dcm_pkg;

  // Frame geometry and field widths.
  localparam int unsigned WIDTH     = 640;
  localparam int unsigned HEIGHT    = 480;
  localparam int unsigned CW        = $clog2(WIDTH);
  localparam int unsigned RW        = $clog2(HEIGHT);
  localparam int unsigned DW        = ($clog2(WIDTH + 1) > $clog2(HEIGHT + 1)) ?
                                      $clog2(WIDTH + 1) : $clog2(HEIGHT + 1);
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned FW        = 4;
  localparam int unsigned NFACT     = 2 ** FW;
  localparam int unsigned OUT_ROW_W = 9;
  localparam int unsigned OUT_COL_W = 10;

  // Step counter width of the serial position divider.
  localparam int unsigned DIV_SW    = $clog2(DW + 1);

  // Window and result queue sizing.
  localparam int unsigned WIN         = 3;
  localparam int unsigned MAX_RES     = 2;
  localparam int unsigned PIPE_SLOTS  = 4;
  localparam int unsigned FIFO_DEPTH  = 16;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = FIFO_AW + 1;
  localparam int unsigned READY_LIMIT = FIFO_DEPTH - MAX_RES * PIPE_SLOTS;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [DW-1:0]    dq_t;
  typedef logic [FW-1:0]    fact_t;

  // One window column, held in ascending order.
  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } col_t;

  // One result beat as it sits in the output queue.
  typedef struct packed {
    pix_t                 depth;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } res_t;

  // Quotient and remainder of the last mirrored column, indexed by the raw factor.
  localparam dq_t COL_LAST_DIV [NFACT] = '{
    dq_t'((WIDTH - 1) / 1),  dq_t'((WIDTH - 1) / 1),  dq_t'((WIDTH - 1) / 2),
    dq_t'((WIDTH - 1) / 3),  dq_t'((WIDTH - 1) / 4),  dq_t'((WIDTH - 1) / 5),
    dq_t'((WIDTH - 1) / 6),  dq_t'((WIDTH - 1) / 7),  dq_t'((WIDTH - 1) / 8),
    dq_t'((WIDTH - 1) / 9),  dq_t'((WIDTH - 1) / 10), dq_t'((WIDTH - 1) / 11),
    dq_t'((WIDTH - 1) / 12), dq_t'((WIDTH - 1) / 13), dq_t'((WIDTH - 1) / 14),
    dq_t'((WIDTH - 1) / 15)
  };

  localparam fact_t COL_LAST_MOD [NFACT] = '{
    fact_t'((WIDTH - 1) % 1),  fact_t'((WIDTH - 1) % 1),  fact_t'((WIDTH - 1) % 2),
    fact_t'((WIDTH - 1) % 3),  fact_t'((WIDTH - 1) % 4),  fact_t'((WIDTH - 1) % 5),
    fact_t'((WIDTH - 1) % 6),  fact_t'((WIDTH - 1) % 7),  fact_t'((WIDTH - 1) % 8),
    fact_t'((WIDTH - 1) % 9),  fact_t'((WIDTH - 1) % 10), fact_t'((WIDTH - 1) % 11),
    fact_t'((WIDTH - 1) % 12), fact_t'((WIDTH - 1) % 13), fact_t'((WIDTH - 1) % 14),
    fact_t'((WIDTH - 1) % 15)
  };

  // Number of output rows and columns kept for each factor.
  localparam dq_t ROW_LIM [NFACT] = '{
    dq_t'(HEIGHT / 1),  dq_t'(HEIGHT / 1),  dq_t'(HEIGHT / 2),  dq_t'(HEIGHT / 3),
    dq_t'(HEIGHT / 4),  dq_t'(HEIGHT / 5),  dq_t'(HEIGHT / 6),  dq_t'(HEIGHT / 7),
    dq_t'(HEIGHT / 8),  dq_t'(HEIGHT / 9),  dq_t'(HEIGHT / 10), dq_t'(HEIGHT / 11),
    dq_t'(HEIGHT / 12), dq_t'(HEIGHT / 13), dq_t'(HEIGHT / 14), dq_t'(HEIGHT / 15)
  };

  localparam dq_t COL_LIM [NFACT] = '{
    dq_t'(WIDTH / 1),  dq_t'(WIDTH / 1),  dq_t'(WIDTH / 2),  dq_t'(WIDTH / 3),
    dq_t'(WIDTH / 4),  dq_t'(WIDTH / 5),  dq_t'(WIDTH / 6),  dq_t'(WIDTH / 7),
    dq_t'(WIDTH / 8),  dq_t'(WIDTH / 9),  dq_t'(WIDTH / 10), dq_t'(WIDTH / 11),
    dq_t'(WIDTH / 12), dq_t'(WIDTH / 13), dq_t'(WIDTH / 14), dq_t'(WIDTH / 15)
  };

  // A factor of zero behaves as one.
  function automatic fact_t eff_factor(input fact_t f);
    return (f == '0) ? fact_t'(1) : f;
  endfunction

endpackage

### hw/rtl/dcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcm_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 640,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dcm_div.sv
// Bit-serial restoring divider of a position by the decimation factor.
module dcm_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dcm_pkg::dq_t    dividend_i,
  input  dcm_pkg::fact_t  divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output dcm_pkg::dq_t    quot_o,
  output dcm_pkg::fact_t  rem_o
);

  logic [dcm_pkg::DIV_SW-1:0] step_q;
  logic                       busy_q;
  dcm_pkg::dq_t               quot_q;
  dcm_pkg::fact_t             rem_q;
  dcm_pkg::fact_t             dsr_q;
  logic [dcm_pkg::FW:0]       rem_sh;
  logic [dcm_pkg::FW:0]       rem_sub;
  logic                       fits;

  assign rem_sh  = {rem_q, quot_q[dcm_pkg::DW-1]};
  assign fits    = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= dcm_pkg::DIV_SW'(dcm_pkg::DW);
    end else if (busy_q) begin
      step_q <= step_q - dcm_pkg::DIV_SW'(1);
      if (step_q == dcm_pkg::DIV_SW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[dcm_pkg::DW-2:0], fits};
      rem_q  <= fits ? rem_sub[dcm_pkg::FW-1:0] : rem_sh[dcm_pkg::FW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (step_q == dcm_pkg::DIV_SW'(1)) && !start_i;
  assign quot_o = {quot_q[dcm_pkg::DW-2:0], fits};
  assign rem_o  = fits ? rem_sub[dcm_pkg::FW-1:0] : rem_sh[dcm_pkg::FW-1:0];

endmodule

### hw/rtl/dcm_col_cell.sv
// One column cell of the 3x3 window: holds a sorted column and hands it on per pixel.
module dcm_col_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  dcm_pkg::col_t col_i,
  output dcm_pkg::col_t col_o
);

  dcm_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

### hw/rtl/depth_median3x3_decimate.sv
// Results pass the line store read, column cell and candidate registers to the output queue.
// Throughput: one input beat per cycle and one result beat per cycle; ready falls while the
// output queue holds more than 8 beats, and during a factor write and the position rescale.
// Reset: asynchronous, active low; clears the position, window, queue and sets the factor to 1.
// The two line stores are not cleared: every entry is written before a median ever uses it.
module depth_median3x3_decimate (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Pixel input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dcm_pkg::PIX_W-1:0]            depth_sample_i,
  input  logic                                 frame_start_i,
  // Result output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dcm_pkg::PIX_W-1:0]            depth_out_o,
  output logic [dcm_pkg::OUT_ROW_W-1:0]        out_row_o,
  output logic [dcm_pkg::OUT_COL_W-1:0]        out_col_o,
  output logic                                 last_of_run_o,
  // Decimation factor register.
  input  logic                                 cfg_we_i,
  input  logic [dcm_pkg::FW-1:0]               cfg_data_i
);

  // Everything a pixel carries down the pipeline besides the window itself.
  typedef struct packed {
    dcm_pkg::pix_t                 sample;
    logic [dcm_pkg::CW-1:0]        col;
    logic                          med_keep;
    logic                          bord_keep;
    logic [dcm_pkg::OUT_ROW_W-1:0] med_row;
    logic [dcm_pkg::OUT_COL_W-1:0] med_col;
    logic [dcm_pkg::OUT_ROW_W-1:0] bord_row;
    logic [dcm_pkg::OUT_COL_W-1:0] bord_col;
  } info_t;

  function automatic dcm_pkg::col_t sort3(input dcm_pkg::pix_t a, input dcm_pkg::pix_t b,
                                          input dcm_pkg::pix_t c);
    dcm_pkg::pix_t x0;
    dcm_pkg::pix_t x1;
    dcm_pkg::pix_t x2;
    dcm_pkg::pix_t t;
    dcm_pkg::col_t r;
    x0 = a;
    x1 = b;
    x2 = c;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    r.lo = x0;
    r.md = x1;
    r.hi = x2;
    return r;
  endfunction

  function automatic dcm_pkg::pix_t max3(input dcm_pkg::pix_t a, input dcm_pkg::pix_t b,
                                         input dcm_pkg::pix_t c);
    dcm_pkg::pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic dcm_pkg::pix_t min3(input dcm_pkg::pix_t a, input dcm_pkg::pix_t b,
                                         input dcm_pkg::pix_t c);
    dcm_pkg::pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic dcm_pkg::pix_t med3(input dcm_pkg::pix_t a, input dcm_pkg::pix_t b,
                                         input dcm_pkg::pix_t c);
    dcm_pkg::pix_t lo;
    dcm_pkg::pix_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hi = (hi < c) ? hi : c;
    return (lo > hi) ? lo : hi;
  endfunction

  // ---------------------------------------------------------------------------
  // Position tracking. Besides the raw row and column we keep the row and the
  // mirrored column already split into quotient and remainder by the factor, so
  // the keep decision needs no divider on the pixel path.
  // ---------------------------------------------------------------------------
  dcm_pkg::fact_t          fact_q;
  dcm_pkg::fact_t          fe;
  logic [dcm_pkg::RW-1:0]  row_q, row_d, r_cur;
  logic [dcm_pkg::CW-1:0]  col_q, col_d, c_cur;
  dcm_pkg::dq_t            rdiv_q, rdiv_d, rdiv_cur;
  dcm_pkg::dq_t            xdiv_q, xdiv_d, xdiv_cur;
  dcm_pkg::fact_t          rmod_q, rmod_d, rmod_cur;
  dcm_pkg::fact_t          xmod_q, xmod_d, xmod_cur;

  logic                    accept;
  logic                    div_busy;
  logic                    row_busy, row_done, col_busy, col_done;
  dcm_pkg::dq_t            row_quot, col_quot;
  dcm_pkg::fact_t          row_rem, col_rem;
  dcm_pkg::fact_t          new_fe;

  assign fe     = dcm_pkg::eff_factor(fact_q);
  assign new_fe = dcm_pkg::eff_factor(cfg_data_i);
  assign accept = in_valid_i && in_ready_o;

  // A frame start restarts at raw (0,0), whose mirrored column is the last one.
  always_comb begin
    if (frame_start_i) begin
      r_cur    = '0;
      c_cur    = '0;
      rdiv_cur = '0;
      rmod_cur = '0;
      xdiv_cur = dcm_pkg::COL_LAST_DIV[fact_q];
      xmod_cur = dcm_pkg::COL_LAST_MOD[fact_q];
    end else begin
      r_cur    = row_q;
      c_cur    = col_q;
      rdiv_cur = rdiv_q;
      rmod_cur = rmod_q;
      xdiv_cur = xdiv_q;
      xmod_cur = xmod_q;
    end
  end

  // The median produced now belongs to the pixel one row up and one raw column
  // to the left, that is one mirrored column to the right.
  dcm_pkg::fact_t rm_mod, xp_mod;
  dcm_pkg::dq_t   rm_div, xp_div;
  logic           xp_wrap, med_en, bord_en, med_keep, bord_keep;

  always_comb begin
    rm_mod  = (rmod_cur == '0) ? fe - dcm_pkg::fact_t'(1) : rmod_cur - dcm_pkg::fact_t'(1);
    rm_div  = (rmod_cur == '0) ? rdiv_cur - dcm_pkg::dq_t'(1) : rdiv_cur;
    xp_wrap = (xmod_cur == fe - dcm_pkg::fact_t'(1));
    xp_mod  = xp_wrap ? '0 : xmod_cur + dcm_pkg::fact_t'(1);
    xp_div  = xp_wrap ? xdiv_cur + dcm_pkg::dq_t'(1) : xdiv_cur;

    med_en  = (r_cur >= dcm_pkg::RW'(2)) && (c_cur >= dcm_pkg::CW'(2));
    bord_en = (r_cur == '0) || (r_cur == dcm_pkg::RW'(dcm_pkg::HEIGHT - 1)) ||
              (c_cur == '0) || (c_cur == dcm_pkg::CW'(dcm_pkg::WIDTH - 1));

    med_keep  = med_en && (rm_mod == '0) && (xp_mod == '0) &&
                (rm_div < dcm_pkg::ROW_LIM[fact_q]) && (xp_div < dcm_pkg::COL_LIM[fact_q]);
    bord_keep = bord_en && (rmod_cur == '0) && (xmod_cur == '0) &&
                (rdiv_cur < dcm_pkg::ROW_LIM[fact_q]) && (xdiv_cur < dcm_pkg::COL_LIM[fact_q]);
  end

  // Advance to the next raw position, wrapping at the end of a row and frame.
  always_comb begin
    row_d  = r_cur;
    col_d  = c_cur;
    rdiv_d = rdiv_cur;
    rmod_d = rmod_cur;
    xdiv_d = xdiv_cur;
    xmod_d = xmod_cur;
    if (c_cur == dcm_pkg::CW'(dcm_pkg::WIDTH - 1)) begin
      col_d  = '0;
      xdiv_d = dcm_pkg::COL_LAST_DIV[fact_q];
      xmod_d = dcm_pkg::COL_LAST_MOD[fact_q];
      if (r_cur == dcm_pkg::RW'(dcm_pkg::HEIGHT - 1)) begin
        row_d  = '0;
        rdiv_d = '0;
        rmod_d = '0;
      end else begin
        row_d = r_cur + dcm_pkg::RW'(1);
        if (rmod_cur == fe - dcm_pkg::fact_t'(1)) begin
          rmod_d = '0;
          rdiv_d = rdiv_cur + dcm_pkg::dq_t'(1);
        end else begin
          rmod_d = rmod_cur + dcm_pkg::fact_t'(1);
        end
      end
    end else begin
      col_d = c_cur + dcm_pkg::CW'(1);
      if (xmod_cur == '0) begin
        xmod_d = fe - dcm_pkg::fact_t'(1);
        xdiv_d = xdiv_cur - dcm_pkg::dq_t'(1);
      end else begin
        xmod_d = xmod_cur - dcm_pkg::fact_t'(1);
      end
    end
  end

  // A factor write rescales the held position with two small serial dividers;
  // no pixel is taken until they finish.
  dcm_div u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we_i),
    .dividend_i (dcm_pkg::DW'(row_q)),
    .divisor_i  (new_fe),
    .busy_o     (row_busy),
    .done_o     (row_done),
    .quot_o     (row_quot),
    .rem_o      (row_rem)
  );

  dcm_div u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we_i),
    .dividend_i (dcm_pkg::DW'(dcm_pkg::CW'(dcm_pkg::WIDTH - 1) - col_q)),
    .divisor_i  (new_fe),
    .busy_o     (col_busy),
    .done_o     (col_done),
    .quot_o     (col_quot),
    .rem_o      (col_rem)
  );

  assign div_busy = row_busy || col_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fact_q <= dcm_pkg::fact_t'(1);
      row_q  <= '0;
      col_q  <= '0;
      rdiv_q <= '0;
      rmod_q <= '0;
      xdiv_q <= dcm_pkg::COL_LAST_DIV[1];
      xmod_q <= dcm_pkg::COL_LAST_MOD[1];
    end else begin
      if (cfg_we_i) begin
        fact_q <= cfg_data_i;
      end
      if (accept) begin
        row_q  <= row_d;
        col_q  <= col_d;
        rdiv_q <= rdiv_d;
        rmod_q <= rmod_d;
        xdiv_q <= xdiv_d;
        xmod_q <= xmod_d;
      end
      if (row_done) begin
        rdiv_q <= row_quot;
        rmod_q <= row_rem;
      end
      if (col_done) begin
        xdiv_q <= col_quot;
        xmod_q <= col_rem;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. Both are read at the raw column in the accept cycle; the data
  // comes back in stage 1, where the rows move down by one.
  // ---------------------------------------------------------------------------
  logic   v1_q, v2_q, v3_q;
  info_t  info0, info1_q, info2_q, info3_q;
  dcm_pkg::pix_t up1, up2;

  always_comb begin
    info0.sample    = depth_sample_i;
    info0.col       = c_cur;
    info0.med_keep  = med_keep;
    info0.bord_keep = bord_keep;
    info0.med_row   = dcm_pkg::OUT_ROW_W'(rm_div);
    info0.med_col   = dcm_pkg::OUT_COL_W'(xp_div);
    info0.bord_row  = dcm_pkg::OUT_ROW_W'(rdiv_cur);
    info0.bord_col  = dcm_pkg::OUT_COL_W'(xdiv_cur);
  end

  dcm_ram #(
    .DATA_W (dcm_pkg::PIX_W),
    .DEPTH  (dcm_pkg::WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (info1_q.col),
    .wdata_i (info1_q.sample),
    .raddr_i (c_cur),
    .rdata_o (up1)
  );

  dcm_ram #(
    .DATA_W (dcm_pkg::PIX_W),
    .DEPTH  (dcm_pkg::WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (info1_q.col),
    .wdata_i (up1),
    .raddr_i (c_cur),
    .rdata_o (up2)
  );

  // ---------------------------------------------------------------------------
  // Window: a chain of column cells. The newest column is sorted as it enters,
  // and every accepted pixel shifts the whole chain by one.
  // ---------------------------------------------------------------------------
  dcm_pkg::col_t chain_in  [dcm_pkg::WIN];
  dcm_pkg::col_t chain_out [dcm_pkg::WIN];

  assign chain_in[0] = sort3(up2, up1, info1_q.sample);

  for (genvar k = 0; k < dcm_pkg::WIN; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign chain_in[k] = chain_out[k-1];
    end
    dcm_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (v1_q),
      .col_i   (chain_in[k]),
      .col_o   (chain_out[k])
    );
  end

  // Stage 2 reduces the three sorted columns to three candidates; stage 3 takes
  // their median, which is the median of all nine.
  dcm_pkg::pix_t lo_q, md_q, hi_q, median;

  assign median = med3(lo_q, md_q, hi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    info1_q <= info0;
    info2_q <= info1_q;
    info3_q <= info2_q;
    lo_q    <= max3(chain_out[0].lo, chain_out[1].lo, chain_out[2].lo);
    md_q    <= med3(chain_out[0].md, chain_out[1].md, chain_out[2].md);
    hi_q    <= min3(chain_out[0].hi, chain_out[1].hi, chain_out[2].hi);
  end

  // ---------------------------------------------------------------------------
  // Output queue. A pixel may add two beats at once: the delayed median first,
  // then its own border value. Ready is held back early enough that every pixel
  // already in the pipeline still finds room.
  // ---------------------------------------------------------------------------
  dcm_pkg::res_t                 fifo_q [dcm_pkg::FIFO_DEPTH];
  logic [dcm_pkg::FIFO_AW-1:0]   wp_q, rp_q;
  logic [dcm_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [1:0]                    n_push;
  logic                          pop;
  dcm_pkg::res_t                 med_res, bord_res, first_res, head;

  always_comb begin
    med_res.depth  = median;
    med_res.row    = info3_q.med_row;
    med_res.col    = info3_q.med_col;
    med_res.last   = !info3_q.bord_keep;
    bord_res.depth = info3_q.sample;
    bord_res.row   = info3_q.bord_row;
    bord_res.col   = info3_q.bord_col;
    bord_res.last  = 1'b1;
    first_res      = info3_q.med_keep ? med_res : bord_res;
    n_push         = v3_q ? (2'(info3_q.med_keep) + 2'(info3_q.bord_keep)) : 2'd0;
  end

  assign pop   = out_valid_o && out_ready_i;
  assign cnt_d = cnt_q + dcm_pkg::CNT_W'(n_push) - dcm_pkg::CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + dcm_pkg::FIFO_AW'(n_push);
      rp_q  <= rp_q + dcm_pkg::FIFO_AW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wp_q] <= first_res;
    end
    if (n_push == 2'd2) begin
      fifo_q[wp_q + dcm_pkg::FIFO_AW'(1)] <= bord_res;
    end
  end

  assign head          = fifo_q[rp_q];
  assign out_valid_o   = (cnt_q != '0);
  assign depth_out_o   = head.depth;
  assign out_row_o     = head.row;
  assign out_col_o     = head.col;
  assign last_of_run_o = head.last;

  assign in_ready_o = !div_busy && !cfg_we_i &&
                      (cnt_q <= dcm_pkg::CNT_W'(dcm_pkg::READY_LIMIT));

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (cnt_d <= dcm_pkg::CNT_W'(dcm_pkg::FIFO_DEPTH)))
    else $error("output queue overflow");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dcm_pkg::CNT_W'(dcm_pkg::FIFO_DEPTH))
    else $error("output queue count out of range");

  a_rescale_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !in_ready_o)
    else $error("pixel taken while the position is being rescaled");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_start_i) |=> (v1_q && (info1_q.col == '0)))
    else $error("frame start did not restart at column zero");

endmodule

### dv/tb.sv
// Self-checking testbench for the depth median filter with mirroring and decimation.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A run with no beat on either channel for this many cycles is taken as a hang.
  localparam int STUCK_LIMIT = 1000;

  // The scoreboard keeps its own copy of the line stores, the 3x3 window, the raster
  // position and the decimation factor. From each accepted pixel beat it works out
  // the result beats that must follow, and it checks them in order as they arrive.
  class median_scoreboard;
    dcm_pkg::pix_t  upper_row  [dcm_pkg::WIDTH];
    dcm_pkg::pix_t  upper2_row [dcm_pkg::WIDTH];
    dcm_pkg::pix_t  win        [9];
    int unsigned    row_pos;
    int unsigned    col_pos;
    dcm_pkg::fact_t factor;
    dcm_pkg::res_t  due [$];
    int             errors;
    int             checked;
    int             pixels;
    int             paired_steps;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        upper2_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_pos      = 0;
      col_pos      = 0;
      factor       = dcm_pkg::fact_t'(1);
      errors       = 0;
      checked      = 0;
      pixels       = 0;
      paired_steps = 0;
    endfunction

    // The median is the value with at most four others below it and at
    // least five at or below it.
    function dcm_pkg::pix_t window_median();
      int i;
      int j;
      int below;
      int same;
      for (i = 0; i < 9; i++) begin
        below = 0;
        same  = 0;
        for (j = 0; j < 9; j++) begin
          if (win[j] < win[i]) below++;
          else if (win[j] == win[i]) same++;
        end
        if (below <= 4 && below + same > 4) return win[i];
      end
      return win[4];
    endfunction

    // Queues a pixel if its row and mirrored column survive decimation.
    function int queue_if_kept(int unsigned row, int unsigned mcol, dcm_pkg::pix_t val);
      int unsigned   f;
      dcm_pkg::res_t item;
      f = (factor == '0) ? 1 : factor;
      if (row % f != 0 || mcol % f != 0) return 0;
      if (row / f >= dcm_pkg::HEIGHT / f || mcol / f >= dcm_pkg::WIDTH / f) return 0;
      item.depth = val;
      item.row   = dcm_pkg::OUT_ROW_W'(row / f);
      item.col   = dcm_pkg::OUT_COL_W'(mcol / f);
      item.last  = 1'b0;
      due.push_back(item);
      return 1;
    endfunction

    function void note_pixel(dcm_pkg::pix_t sample, logic fs);
      int unsigned   r;
      int unsigned   c;
      int            k;
      int            made;
      dcm_pkg::pix_t above;
      dcm_pkg::pix_t above2;
      made = 0;
      if (fs) begin
        row_pos = 0;
        col_pos = 0;
      end
      r      = row_pos;
      c      = col_pos;
      above  = upper_row[c];
      above2 = upper2_row[c];
      for (k = 0; k < 6; k++) win[k] = win[k + 3];
      win[6]        = above2;
      win[7]        = above;
      win[8]        = sample;
      upper2_row[c] = above;
      upper_row[c]  = sample;
      // The delayed median of the pixel above-left goes out before this pixel's border copy.
      if (r >= 2 && c >= 2) made += queue_if_kept(r - 1, dcm_pkg::WIDTH - c, window_median());
      if (r == 0 || r == dcm_pkg::HEIGHT - 1 || c == 0 || c == dcm_pkg::WIDTH - 1)
        made += queue_if_kept(r, dcm_pkg::WIDTH - 1 - c, sample);
      if (made > 0) due[due.size() - 1].last = 1'b1;
      if (made > 1) paired_steps++;
      c++;
      if (c >= dcm_pkg::WIDTH) begin
        c = 0;
        r++;
        if (r >= dcm_pkg::HEIGHT) r = 0;
      end
      row_pos = r;
      col_pos = c;
      pixels++;
    endfunction

    function void check_result(dcm_pkg::pix_t d, logic [dcm_pkg::OUT_ROW_W-1:0] r,
                               logic [dcm_pkg::OUT_COL_W-1:0] c, logic l);
      dcm_pkg::res_t want;
      checked++;
      if (due.size() == 0) begin
        errors++;
        $error("unexpected result beat: depth_out %0d out_row %0d out_col %0d", d, r, c);
        return;
      end
      want = due.pop_front();
      if (d !== want.depth) begin
        errors++;
        $error("depth_out: expected %0d, got %0d", want.depth, d);
      end
      if (r !== want.row) begin
        errors++;
        $error("out_row: expected %0d, got %0d", want.row, r);
      end
      if (c !== want.col) begin
        errors++;
        $error("out_col: expected %0d, got %0d", want.col, c);
      end
      if (l !== want.last) begin
        errors++;
        $error("last_of_run: expected %0d, got %0d", want.last, l);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  dcm_pkg::pix_t                 depth_sample = '0;
  logic                          frame_start  = 1'b0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  dcm_pkg::pix_t                 depth_out;
  logic [dcm_pkg::OUT_ROW_W-1:0] out_row;
  logic [dcm_pkg::OUT_COL_W-1:0] out_col;
  logic                          last_of_run;
  logic                          cfg_we       = 1'b0;
  dcm_pkg::fact_t                cfg_data     = '0;

  median_scoreboard board = new();

  // Idling state: each side keeps its own count of beats still to run without any gap.
  int            calm_in       = 0;
  int            idle_cycles   = 0;
  int            factor_writes = 0;
  dcm_pkg::pix_t depth_base    = 16'h0800;

  depth_median3x3_decimate uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .depth_sample_i (depth_sample),
    .frame_start_i  (frame_start),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .depth_out_o    (depth_out),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .last_of_run_o  (last_of_run),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or a few cycles, now and then a long one, and from time to
  // time a stretch of back-to-back beats with no gap at all.
  function automatic int pick_gap(inout int calm_left);
    int roll;
    roll = $urandom_range(0, 999);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (roll < 8) begin
      calm_left = $urandom_range(20, 200);
      return 0;
    end
    if (roll < 650) return 0;
    if (roll < 950) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Depth values: the extremes, runs of near-equal values so that the median sees many
  // ties, and fully random values.
  function automatic dcm_pkg::pix_t next_depth();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 20) begin
      depth_base = dcm_pkg::pix_t'($urandom);
      return depth_base;
    end
    if (roll < 65) return depth_base ^ dcm_pkg::pix_t'($urandom_range(0, 7));
    return dcm_pkg::pix_t'($urandom);
  endfunction

  // The result side stalls at random, one decision per falling edge.
  initial begin : result_sink
    int stall_left;
    int calm_out;
    stall_left = 0;
    calm_out   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(calm_out);
      end
    end
  end

  // All observation happens at the rising edge: result beats are checked before the
  // pixel beat of the same edge is noted, and a factor write updates the copy held by
  // the scoreboard. The watchdog sits last, as it may end the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_result(depth_out, out_row, out_col, last_of_run);
      if (in_valid && in_ready) board.note_pixel(depth_sample, frame_start);
      if (cfg_we) board.factor = cfg_data;
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STUCK_LIMIT) begin
        $error("watchdog: no beat for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, board.pending());
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Offers one pixel beat, after a random gap, and holds it until it is taken. The task
  // is entered and left on a falling edge.
  task automatic send_pixel(input dcm_pkg::pix_t value, input logic fs);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    depth_sample <= value;
    frame_start  <= fs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // A run of raster pixels, optionally opening a new frame, with frame starts scattered
  // through it at the given rate per thousand beats.
  task automatic send_stream(input int count, input bit open_frame, input int noise_pm);
    int   i;
    logic fs;
    for (i = 0; i < count; i++) begin
      fs = (open_frame && i == 0) || ($urandom_range(0, 999) < noise_pm);
      send_pixel(next_depth(), fs);
    end
  endtask

  // The factor is changed only with the block idle: every expected beat has arrived and
  // a few more cycles have passed for any pixel still in flight that yields no result.
  task automatic set_factor(input dcm_pkg::fact_t f);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= f;
    @(negedge clk);
    cfg_we   <= 1'b0;
    factor_writes++;
  endtask

  initial begin : stimulus
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening at the reset factor: field extremes and bit patterns along the
    // top border, then a frame start in the middle of a row.
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h7FFF, 1'b0);
    send_pixel(16'hFFFE, 1'b0);
    send_pixel(16'h00FF, 1'b0);
    send_pixel(16'hFF00, 1'b0);
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    // A factor of zero must behave as one.
    set_factor(dcm_pkg::fact_t'(0));
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h7FFE, 1'b0);
    // The largest factor keeps only mirrored columns that are multiples of fifteen.
    set_factor(dcm_pkg::fact_t'(15));
    send_pixel(16'hC3C3, 1'b1);
    repeat (8) send_pixel(next_depth(), 1'b0);

    // Random part. The first frame runs past the end of row two, so medians appear and
    // the last column of that row gives a median and a border beat in one step. The
    // start of row three then runs at factor two, which keeps every other median.
    set_factor(dcm_pkg::fact_t'(1));
    send_stream(1925, 1'b1, 0);
    set_factor(dcm_pkg::fact_t'(2));
    send_stream(40, 1'b0, 0);

    // Drain: wait for every expected beat, then a little longer for any stray ones.
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d pixel beats and checked %0d result beats, %0d steps giving two.",
             board.pixels, board.checked, board.paired_steps);
    $display("Wrote the factor %0d times, including 0 and 15, with frames restarted mid-row.",
             factor_writes);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dcm_pkg.sv
hw/rtl/dcm_ram.sv
hw/rtl/dcm_div.sv
hw/rtl/dcm_col_cell.sv
hw/rtl/depth_median3x3_decimate.sv
dv/tb.sv
